[hdl/deadline_timer_table_macros.svh]
// Assertion macros shared by the RTL.
`ifndef DEADLINE_TIMER_TABLE_MACROS_SVH
`define DEADLINE_TIMER_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define DTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DTT_ASSERT_NOW(lbl, ante, cons, msg)
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/dtt_pkg.sv]
package dtt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_BITS  = 4;
  localparam int TIME_BITS  = 48;
  localparam logic [TIME_BITS-1:0] ROLLBACK_MS = 48'd3600000;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CANCEL  = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_EXPIRE  = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [SLOT_BITS-1:0] slot_id;
    logic [TIME_BITS-1:0] period_ms;
    logic                 repeat_mode;
    logic                 restart_now;
    logic [TIME_BITS-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_BITS-1:0] result_slot;
    logic                 expired_flag;
    logic [TIME_BITS-1:0] wait_ms;
    logic                 front_notice;
    logic                 any_active;
    logic                 last_result;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic simple_out;
    logic add_scan;
    logic add_write;
    logic slot_exec;
    logic due_scan;
    logic sel_scan;
    logic sel_emit;
    logic qry_scan;
    logic qry_out;
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       full;
    logic       any_on;
    logic       idx_last;
    logic       found;
    logic       more_due;
  } dp_stat_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

endpackage

[hdl/deadline_timer_table.sv]
// Channel   Handshake              Payload  Width
// command   start / busy           cmd      105 bits, taken when start && !busy
// result    done (one-cycle strobe) rsp     58 bits, one or more per transaction
//
// Cancel, refresh and reset finish from the dispatch state, as do unknown
// opcodes, a full add and an expire with no active slot. Add and query take one
// sweep over the slot table. Expire takes one sweep to mark due slots, then one
// min-search sweep per result, or a single such sweep when nothing is due. The
// table has a single read port, which sets these sweep lengths.
// Reset clears all slot flags at once; no clearing pass is needed.
// Results cannot be held off; busy drops as the last one is presented.
`include "deadline_timer_table_macros.svh"

module deadline_timer_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dtt_pkg::cmd_t cmd,
  output logic          done,
  output dtt_pkg::rsp_t rsp
);

  dtt_pkg::dp_ctl_t  ctl;
  dtt_pkg::dp_stat_t stat;

  dtt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  dtt_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ctl  (ctl),
    .stat (stat),
    .done (done),
    .rsp  (rsp)
  );

  `DTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `DTT_ASSERT_NOW(a_done_in_txn, done, $past(busy), "result outside a transaction")
  `DTT_ASSERT_NEXT(a_last_ends, done && rsp.last_result, !done, "result after last result")

endmodule

[hdl/dtt_ctrl.sv]
module dtt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dtt_pkg::dp_stat_t stat,
  output dtt_pkg::dp_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_ADD_SCAN, S_ADD_WR, S_DUE_SCAN, S_SEL_SCAN, S_EMIT, S_QRY_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.opcode)
          dtt_pkg::OP_ADD: begin
            if (stat.full) begin
              ctl.simple_out = 1'b1;
              state_next     = S_IDLE;
            end else begin
              state_next = S_ADD_SCAN;
            end
          end
          dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH, dtt_pkg::OP_RESET: begin
            ctl.slot_exec = 1'b1;
            state_next    = S_IDLE;
          end
          dtt_pkg::OP_EXPIRE: begin
            if (stat.any_on) begin
              state_next = S_DUE_SCAN;
            end else begin
              ctl.simple_out = 1'b1;
              state_next     = S_IDLE;
            end
          end
          dtt_pkg::OP_QUERY: begin
            state_next = S_QRY_SCAN;
          end
          default: begin
            ctl.simple_out = 1'b1;
            state_next     = S_IDLE;
          end
        endcase
      end
      S_ADD_SCAN: begin
        ctl.add_scan = 1'b1;
        if (stat.idx_last) state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        ctl.add_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_DUE_SCAN: begin
        ctl.due_scan = 1'b1;
        if (stat.idx_last) state_next = S_SEL_SCAN;
      end
      S_SEL_SCAN: begin
        ctl.sel_scan = 1'b1;
        if (stat.idx_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.found) begin
          ctl.sel_emit = 1'b1;
          state_next   = stat.more_due ? S_SEL_SCAN : S_IDLE;
        end else begin
          ctl.simple_out = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_QRY_SCAN: begin
        ctl.qry_scan = 1'b1;
        if (stat.idx_last) begin
          // S_EMIT forms the result, which is then registered onto rsp
          state_next = S_EMIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (state == S_EMIT && stat.opcode == dtt_pkg::OP_QUERY) begin
      ctl          = '0;
      ctl.qry_out  = 1'b1;
      state_next   = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/dtt_datapath.sv]
module dtt_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dtt_pkg::cmd_t     cmd,
  input  dtt_pkg::dp_ctl_t  ctl,
  output dtt_pkg::dp_stat_t stat,
  output logic              done,
  output dtt_pkg::rsp_t     rsp
);

  localparam int N  = dtt_pkg::SLOT_COUNT;
  localparam int SB = dtt_pkg::SLOT_BITS;
  localparam int TB = dtt_pkg::TIME_BITS;

  logic [TB-1:0] period_mem [N];
  logic [TB-1:0] dl_mem [N];

  dtt_pkg::cmd_t cmd_r;
  logic [N-1:0]  active;
  logic [N-1:0]  repeat_v;
  logic [N-1:0]  due;
  logic [TB-1:0] prev_now;
  logic          notice;
  logic [SB-1:0] idx;
  logic [SB-1:0] best;
  logic [TB-1:0] best_dl;
  logic          found;
  logic          front;
  logic          roll;
  logic [TB-1:0] dl_new;

  logic [N-1:0]  active_next;
  logic [N-1:0]  repeat_next;
  logic [N-1:0]  due_next;
  logic          notice_next;
  logic [SB-1:0] free_slot;
  logic [SB-1:0] addr;
  logic [TB-1:0] rd_p;
  logic [TB-1:0] rd_d;
  logic          wr_en;
  logic          wr_p_en;
  logic [SB-1:0] wr_addr;
  logic [TB-1:0] wr_p;
  logic [TB-1:0] wr_d;
  logic [TB-1:0] base;
  logic          scan_mask;
  dtt_pkg::rsp_t rsp_next;
  logic          done_next;

  always_comb begin
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!active[i]) free_slot = SB'(i);
    end
  end

  assign addr = ctl.sel_emit  ? best :
                ctl.slot_exec ? cmd_r.slot_id : idx;
  assign rd_p = period_mem[addr];
  assign rd_d = dl_mem[addr];

  assign scan_mask = ctl.sel_scan ? due[idx] : active[idx];

  assign stat.opcode   = cmd_r.opcode;
  assign stat.full     = &active;
  assign stat.any_on   = |active;
  assign stat.idx_last = &idx;
  assign stat.found    = found;
  assign stat.more_due = |(due & ~(N'(1) << best));

  always_comb begin
    active_next = active;
    repeat_next = repeat_v;
    due_next    = due;
    notice_next = notice;
    wr_en       = 1'b0;
    wr_p_en     = 1'b0;
    wr_addr     = addr;
    wr_p        = cmd_r.period_ms;
    wr_d        = dtt_pkg::sat_add(cmd_r.now_ms, rd_p);
    base        = cmd_r.restart_now ? cmd_r.now_ms : ((rd_d >= rd_p) ? rd_d - rd_p : '0);
    done_next   = 1'b0;
    rsp_next    = '0;
    rsp_next.status      = dtt_pkg::ST_OK;
    rsp_next.last_result = 1'b1;

    if (ctl.load) begin
      due_next = '0;
    end

    if (ctl.due_scan) begin
      due_next[idx] = active[idx] && (roll || rd_d <= cmd_r.now_ms);
    end

    if (ctl.simple_out) begin
      done_next = 1'b1;
      if (cmd_r.opcode == dtt_pkg::OP_ADD) rsp_next.status = dtt_pkg::ST_FULL;
    end

    if (ctl.add_write) begin
      done_next              = 1'b1;
      active_next[free_slot] = 1'b1;
      repeat_next[free_slot] = cmd_r.repeat_mode;
      wr_en                  = 1'b1;
      wr_p_en                = 1'b1;
      wr_addr                = free_slot;
      wr_d                   = dl_new;
      rsp_next.result_slot   = free_slot;
      rsp_next.front_notice  = front && !notice;
      if (front) notice_next = 1'b1;
    end

    if (ctl.slot_exec) begin
      done_next = 1'b1;
      if (cmd_r.opcode == dtt_pkg::OP_RESET && cmd_r.period_ms == rd_p &&
          !cmd_r.restart_now) begin
        // unchanged period counted from the last start: nothing to do
      end else if (!active[cmd_r.slot_id]) begin
        rsp_next.status = dtt_pkg::ST_INACTIVE;
      end else begin
        case (cmd_r.opcode)
          dtt_pkg::OP_CANCEL: begin
            active_next[cmd_r.slot_id] = 1'b0;
          end
          dtt_pkg::OP_REFRESH: begin
            wr_en = 1'b1;
          end
          default: begin
            wr_en   = 1'b1;
            wr_p_en = 1'b1;
            wr_d    = dtt_pkg::sat_add(base, cmd_r.period_ms);
          end
        endcase
      end
    end

    if (ctl.sel_emit) begin
      done_next            = 1'b1;
      due_next[best]       = 1'b0;
      rsp_next.result_slot = best;
      rsp_next.expired_flag = 1'b1;
      rsp_next.last_result = ~|due_next;
      if (repeat_v[best]) begin
        wr_en = 1'b1;
      end else begin
        active_next[best] = 1'b0;
      end
    end

    if (ctl.qry_out) begin
      done_next   = 1'b1;
      notice_next = 1'b0;
      if (found && best_dl > cmd_r.now_ms) rsp_next.wait_ms = best_dl - cmd_r.now_ms;
    end

    // due slots that do not recur are freed before the item ends
    rsp_next.any_active = |(active_next & ~(due_next & ~repeat_v));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_d;
      if (wr_p_en) period_mem[wr_addr] <= wr_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      repeat_v <= '0;
      due      <= '0;
      prev_now <= '0;
      notice   <= 1'b0;
      idx      <= '0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      active   <= active_next;
      repeat_v <= repeat_next;
      due      <= due_next;
      notice   <= notice_next;
      done     <= done_next;
      if (ctl.add_scan || ctl.due_scan || ctl.sel_scan || ctl.qry_scan) begin
        idx <= idx + 1'b1;
      end
      if (ctl.due_scan && (&idx)) prev_now <= cmd_r.now_ms;
      if (ctl.load || ctl.sel_emit) begin
        found <= 1'b0;
      end else if ((ctl.sel_scan || ctl.qry_scan) && scan_mask &&
                   (!found || rd_d < best_dl)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (ctl.load) begin
      cmd_r  <= cmd;
      front  <= 1'b1;
      roll   <= dtt_pkg::sat_add(cmd.now_ms, dtt_pkg::ROLLBACK_MS) < prev_now;
      dl_new <= dtt_pkg::sat_add(cmd.now_ms, cmd.period_ms);
    end
    if (ctl.add_scan && active[idx] &&
        (rd_d < dl_new || (rd_d == dl_new && idx < free_slot))) begin
      front <= 1'b0;
    end
    if ((ctl.sel_scan || ctl.qry_scan) && scan_mask && (!found || rd_d < best_dl)) begin
      best    <= idx;
      best_dl <= rd_d;
    end
  end

endmodule

[verif/deadline_timer_table_checker.sv]
module deadline_timer_table_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  dtt_pkg::cmd_t cmd,
  input  logic          done,
  input  dtt_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending_count,
  output int            expired_seen,
  output int            rollback_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB = dtt_pkg::TIME_BITS;
  localparam int NS = dtt_pkg::SLOT_COUNT;
  localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

  // Shadow copy of the slot table
  logic          tbl_active [NS];
  logic          tbl_repeat [NS];
  logic [TB-1:0] tbl_period [NS];
  logic [TB-1:0] tbl_deadline [NS];
  logic [TB-1:0] last_expire_now;
  logic          notice_raised;

  dtt_pkg::rsp_t expected_rsps[$];
  int            mismatches;

  function automatic logic [TB-1:0] add_clamped(logic [TB-1:0] a, logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? TIME_MAX : s[TB-1:0];
  endfunction

  function automatic logic table_busy();
    foreach (tbl_active[i]) if (tbl_active[i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic push_rsp(dtt_pkg::status_t st, int slot, logic exp_flag,
                          logic [TB-1:0] wait_val, logic notice, logic last);
    dtt_pkg::rsp_t r;
    r.status       = st;
    r.result_slot  = slot[dtt_pkg::SLOT_BITS-1:0];
    r.expired_flag = exp_flag;
    r.wait_ms      = wait_val;
    r.front_notice = notice;
    r.any_active   = table_busy();
    r.last_result  = last;
    expected_rsps.insert(expected_rsps.size(), r);
  endtask

  task automatic predict_timer_op(dtt_pkg::cmd_t c);
    int            free_slot, best, n;
    logic          front, roll;
    logic          due [NS];
    int            picked [$];
    logic [TB-1:0] dl, base, wait_val;
    int            id;
    id = int'(c.slot_id);
    case (c.opcode)
      dtt_pkg::OP_ADD: begin
        free_slot = -1;
        for (int i = 0; i < NS; i++)
          if (!tbl_active[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          push_rsp(dtt_pkg::ST_FULL, 0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          dl = add_clamped(c.now_ms, c.period_ms);
          front = 1'b1;
          for (int i = 0; i < NS; i++)
            if (tbl_active[i] && (tbl_deadline[i] < dl ||
                (tbl_deadline[i] == dl && i < free_slot))) front = 1'b0;
          tbl_active[free_slot]   = 1'b1;
          tbl_repeat[free_slot]   = c.repeat_mode;
          tbl_period[free_slot]   = c.period_ms;
          tbl_deadline[free_slot] = dl;
          front = front && !notice_raised;
          if (front) notice_raised = 1'b1;
          push_rsp(dtt_pkg::ST_OK, free_slot, 1'b0, '0, front, 1'b1);
        end
      end
      dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH: begin
        if (!tbl_active[id]) begin
          push_rsp(dtt_pkg::ST_INACTIVE, 0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          if (c.opcode == dtt_pkg::OP_CANCEL) tbl_active[id] = 1'b0;
          else tbl_deadline[id] = add_clamped(c.now_ms, tbl_period[id]);
          push_rsp(dtt_pkg::ST_OK, 0, 1'b0, '0, 1'b0, 1'b1);
        end
      end
      dtt_pkg::OP_RESET: begin
        // Unchanged period and not from now: success without checking activity
        if (c.period_ms == tbl_period[id] && !c.restart_now) begin
          push_rsp(dtt_pkg::ST_OK, 0, 1'b0, '0, 1'b0, 1'b1);
        end else if (!tbl_active[id]) begin
          push_rsp(dtt_pkg::ST_INACTIVE, 0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          base = (tbl_deadline[id] >= tbl_period[id]) ?
                 tbl_deadline[id] - tbl_period[id] : '0;
          tbl_period[id]   = c.period_ms;
          tbl_deadline[id] = add_clamped(c.restart_now ? c.now_ms : base, c.period_ms);
          push_rsp(dtt_pkg::ST_OK, 0, 1'b0, '0, 1'b0, 1'b1);
        end
      end
      dtt_pkg::OP_EXPIRE: begin
        foreach (due[i]) due[i] = 1'b0;
        if (table_busy()) begin
          roll = add_clamped(c.now_ms, dtt_pkg::ROLLBACK_MS) < last_expire_now;
          if (roll) rollback_seen++;
          last_expire_now = c.now_ms;
          for (int i = 0; i < NS; i++)
            due[i] = tbl_active[i] && (roll || tbl_deadline[i] <= c.now_ms);
        end
        n = 0;
        while (n < NS) begin
          best = -1;
          for (int i = 0; i < NS; i++)
            if (due[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best])) best = i;
          if (best < 0) break;
          due[best] = 1'b0;
          picked.insert(picked.size(), best);
          n++;
        end
        foreach (picked[k]) begin
          if (tbl_repeat[picked[k]])
            tbl_deadline[picked[k]] = add_clamped(c.now_ms, tbl_period[picked[k]]);
          else
            tbl_active[picked[k]] = 1'b0;
        end
        if (n == 0) push_rsp(dtt_pkg::ST_OK, 0, 1'b0, '0, 1'b0, 1'b1);
        foreach (picked[k]) push_rsp(dtt_pkg::ST_OK, picked[k], 1'b1, '0, 1'b0, k == n - 1);
        expired_seen += n;
      end
      dtt_pkg::OP_QUERY: begin
        notice_raised = 1'b0;
        wait_val = '0;
        best = -1;
        for (int i = 0; i < NS; i++)
          if (tbl_active[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
            best = i;
        if (best >= 0 && tbl_deadline[best] > c.now_ms)
          wait_val = tbl_deadline[best] - c.now_ms;
        push_rsp(dtt_pkg::ST_OK, 0, 1'b0, wait_val, 1'b0, 1'b1);
      end
      default: push_rsp(dtt_pkg::ST_OK, 0, 1'b0, '0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic report(string field, longint unsigned want, longint unsigned got);
    fail_count++;
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: result %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    dtt_pkg::rsp_t want;
    if (rst) begin
      foreach (tbl_active[i]) begin
        tbl_active[i]   = 1'b0;
        tbl_repeat[i]   = 1'b0;
        tbl_period[i]   = '0;
        tbl_deadline[i] = '0;
      end
      last_expire_now = '0;
      notice_raised   = 1'b0;
      expected_rsps.delete();
      fail_count    = 0;
      mismatches    = 0;
      expired_seen  = 0;
      rollback_seen = 0;
    end else begin
      // Results precede the next command, so compare before predicting
      if (done) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected", 64'd0, 64'(rsp));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report("status", 64'(want.status), 64'(rsp.status));
          if (rsp.result_slot !== want.result_slot)
            report("result_slot", 64'(want.result_slot), 64'(rsp.result_slot));
          if (rsp.expired_flag !== want.expired_flag)
            report("expired_flag", 64'(want.expired_flag), 64'(rsp.expired_flag));
          if (rsp.wait_ms !== want.wait_ms)
            report("wait_ms", 64'(want.wait_ms), 64'(rsp.wait_ms));
          if (rsp.front_notice !== want.front_notice)
            report("front_notice", 64'(want.front_notice), 64'(rsp.front_notice));
          if (rsp.any_active !== want.any_active)
            report("any_active", 64'(want.any_active), 64'(rsp.any_active));
          if (rsp.last_result !== want.last_result)
            report("last_result", 64'(want.last_result), 64'(rsp.last_result));
        end
      end
      if (start && !busy) predict_timer_op(cmd);
    end
    pending_count = expected_rsps.size();
  end
endmodule

[verif/deadline_timer_table_test.sv]
module deadline_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] OP_BAD = 3'd7;
  localparam int TB = dtt_pkg::TIME_BITS;
  localparam int NS = dtt_pkg::SLOT_COUNT;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  dtt_pkg::cmd_t cmd;
  logic done;
  dtt_pkg::rsp_t rsp;
  int   fail_count, pending_count, expired_seen, rollback_seen;
  int   idle_cycles;
  int   sent;
  logic gaps_on;
  logic [TB-1:0] clock_ms;
  logic [NS-1:0] slot_used;

  deadline_timer_table u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
  );

  deadline_timer_table_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .fail_count(fail_count), .pending_count(pending_count),
    .expired_seen(expired_seen), .rollback_seen(rollback_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TB-1:0] rand_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [TB-1:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return rand_time();
      2:       return {TB{1'b1}};
      default: return TB'($urandom_range(1, 400));
    endcase
  endfunction

  // Issue one transaction; slot_used tracks slots whose period was written
  task automatic send_cmd(logic [2:0] op, int id, logic [TB-1:0] per,
                          logic rep, logic fnow, logic [TB-1:0] now);
    int gap;
    // Never let a reset shortcut read a period that was never written
    if (op == dtt_pkg::OP_RESET && !slot_used[id] && !fnow) fnow = 1'b1;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 6));
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= '{opcode: op, slot_id: id[dtt_pkg::SLOT_BITS-1:0], period_ms: per,
               repeat_mode: rep, restart_now: fnow, now_ms: now};
    while (busy) @(negedge clk);
    @(negedge clk);
    start <= 1'b0;
    sent++;
    if (op == dtt_pkg::OP_ADD) begin
      while (!done) @(negedge clk);
      if (rsp.status == dtt_pkg::ST_OK) slot_used[rsp.result_slot] = 1'b1;
    end
  endtask

  task automatic send_random();
    int  r;
    logic [2:0] op;
    r = int'($urandom_range(0, 99));
    if (r < 30)      op = dtt_pkg::OP_ADD;
    else if (r < 40) op = dtt_pkg::OP_CANCEL;
    else if (r < 50) op = dtt_pkg::OP_REFRESH;
    else if (r < 62) op = dtt_pkg::OP_RESET;
    else if (r < 85) op = dtt_pkg::OP_EXPIRE;
    else if (r < 97) op = dtt_pkg::OP_QUERY;
    else             op = 3'($urandom_range(6, 7));
    // Mostly advance time; occasionally jump backward past the rollback window
    r = int'($urandom_range(0, 99));
    if (r < 3)       clock_ms = (clock_ms > 48'd4000000) ? clock_ms - 48'd4000000 : '0;
    else if (r < 5)  clock_ms = rand_time();
    else             clock_ms = clock_ms + TB'($urandom_range(0, 120));
    send_cmd(op, int'($urandom_range(0, NS - 1)), rand_period(), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), clock_ms);
  endtask

  initial begin
    logic [TB-1:0] ones;
    int wait_cycles;
    ones      = {TB{1'b1}};
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    sent      = 0;
    gaps_on   = 1'b1;
    clock_ms  = 48'd5000000;
    slot_used = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, fill, full, ties, saturation, reset paths, rollback
    send_cmd(dtt_pkg::OP_EXPIRE, 0, '0, 1'b0, 1'b0, 48'd100);
    send_cmd(dtt_pkg::OP_QUERY, 0, '0, 1'b0, 1'b0, 48'd100);
    send_cmd(dtt_pkg::OP_CANCEL, 15, '0, 1'b0, 1'b0, 48'd100);
    for (int i = 0; i < NS; i++)
      send_cmd(dtt_pkg::OP_ADD, 0, (i < 2) ? ones : 48'd10, i[0], 1'b0,
               (i == 0) ? ones : 48'd100);
    send_cmd(dtt_pkg::OP_ADD, 0, 48'd5, 1'b0, 1'b0, 48'd100);
    send_cmd(dtt_pkg::OP_RESET, 3, 48'd10, 1'b0, 1'b0, 48'd100);
    send_cmd(dtt_pkg::OP_RESET, 3, 48'd30, 1'b0, 1'b0, 48'd100);
    send_cmd(dtt_pkg::OP_RESET, 4, 48'd7, 1'b0, 1'b1, 48'd104);
    send_cmd(dtt_pkg::OP_REFRESH, 5, '0, 1'b0, 1'b0, 48'd90);
    send_cmd(dtt_pkg::OP_QUERY, 0, '0, 1'b0, 1'b0, 48'd100);
    send_cmd(dtt_pkg::OP_EXPIRE, 0, '0, 1'b0, 1'b0, 48'd115);
    send_cmd(dtt_pkg::OP_EXPIRE, 0, '0, 1'b0, 1'b0, ones);
    send_cmd(dtt_pkg::OP_EXPIRE, 0, '0, 1'b0, 1'b0, 48'd0);
    send_cmd(OP_BAD, 0, ones, 1'b1, 1'b1, ones);

    // Drain the table and pause until all results have arrived
    for (int i = 0; i < NS; i++) send_cmd(dtt_pkg::OP_CANCEL, i, '0, 1'b0, 1'b0, 48'd0);
    while (pending_count != 0) @(negedge clk);

    while (sent < 460) begin
      if (sent > 420) gaps_on = 1'b0;
      send_random();
    end

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);
    $display("Ran %0d commands: %0d timers expired, %0d clock rollbacks seen.",
             sent, expired_seen, rollback_seen);
    if (fail_count == 0 && pending_count == 0) $display("deadline_timer_table_test passed");
    else $display("deadline_timer_table_test failed");
    $finish;
  end

  // Count cycles with no transaction on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("deadline_timer_table_test failed");
        $finish;
      end
    end
  end
endmodule
